// ===== rtl/qcr_pkg.sv =====
package qcr_pkg;

  // default configuration
  localparam int TABLE_DEPTH_DEF     = 48;
  localparam int RATIO_FRAC_BITS_DEF = 28;
  localparam int ACC_WIDTH_DEF       = 64;

  localparam int SAMPLE_W    = 16;
  localparam int TSEL_W      = 3;
  localparam int NUM_TABLES  = 5;
  localparam int ROM_ENTRIES = 132;
  localparam int ROM_IDX_W   = 8;
  localparam int PHASE_W     = 6;
  localparam int RATIO_W     = 32;
  localparam int SUM_W       = 64;
  localparam int PROD_STEPS  = 24;
  localparam int STEP_W      = 5;
  localparam int TSEL_MAX    = 4;
  localparam int TSEL_RESET  = 4;

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_RATIO = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_OK       = 2'd1,
    ST_REF_ZERO = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_ACC_ADD,
    S_PROD,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic acc_mul;
    logic acc_add;
    logic clear;
    logic prod_start;
    logic prod_step;
    logic div_init;
    logic div_step;
    logic finish;
  } dp_ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic prod_done;
    logic den_zero;
    logic div_done;
    logic out_busy;
  } dp_stat_t;

  localparam int ROM_BASE [NUM_TABLES]   = '{0, 16, 28, 76, 84};
  localparam int ROM_PERIOD [NUM_TABLES] = '{16, 12, 48, 8, 48};

  // sine, cosine pairs; each table holds a whole number of periods
  localparam int ROM_SC [ROM_ENTRIES][2] = '{
    '{3212,32610},'{15447,28899},'{25330,20788},'{31357,9512},
    '{32610,-3212},'{28899,-15447},'{20788,-25330},'{9512,-31357},
    '{-3212,-32610},'{-15447,-28899},'{-25330,-20788},'{-31357,-9512},
    '{-32610,3212},'{-28899,15447},'{-20788,25330},'{-9512,31357},
    '{4277,32488},'{19948,25997},'{30274,12540},'{32488,-4277},
    '{25997,-19948},'{12540,-30274},'{-4277,-32488},'{-19948,-25997},
    '{-30274,-12540},'{-32488,4277},'{-25997,19948},'{-12540,30274},
    '{10533,31029},'{27246,18205},'{32698,-2143},'{24636,-21605},
    '{6393,-32138},'{-14493,-29389},'{-29389,-14493},'{-32138,6393},
    '{-21605,24636},'{-2143,32698},'{18205,27246},'{31029,10533},
    '{31029,-10533},'{18205,-27246},'{-2143,-32698},'{-21605,-24636},
    '{-32138,-6393},'{-29389,14493},'{-14493,29389},'{6393,32138},
    '{24636,21605},'{32698,2143},'{27246,-18205},'{10533,-31029},
    '{-10533,-31029},'{-27246,-18205},'{-32698,2143},'{-24636,21605},
    '{-6393,32138},'{14493,29389},'{29389,14493},'{32138,-6393},
    '{21605,-24636},'{2143,-32698},'{-18205,-27246},'{-31029,-10533},
    '{-31029,10533},'{-18205,27246},'{2143,32698},'{21605,24636},
    '{32138,6393},'{29389,-14493},'{14493,-29389},'{-6393,-32138},
    '{-24636,-21605},'{-32698,-2143},'{-27246,18205},'{-10533,31029},
    '{6393,32138},'{27246,18205},'{32138,-6393},'{18205,-27246},
    '{-6393,-32138},'{-27246,-18205},'{-32138,6393},'{-18205,27246},
    '{14493,29389},'{32138,6393},'{24636,-21605},'{-2143,-32698},
    '{-27246,-18205},'{-31029,10533},'{-10533,31029},'{18205,27246},
    '{32698,2143},'{21605,-24636},'{-6393,-32138},'{-29389,-14493},
    '{-29389,14493},'{-6393,32138},'{21605,24636},'{32698,-2143},
    '{18205,-27246},'{-10533,-31029},'{-31029,-10533},'{-27246,18205},
    '{-2143,32698},'{24636,21605},'{32138,-6393},'{14493,-29389},
    '{-14493,-29389},'{-32138,-6393},'{-24636,21605},'{2143,32698},
    '{27246,18205},'{31029,-10533},'{10533,-31029},'{-18205,-27246},
    '{-32698,-2143},'{-21605,24636},'{6393,32138},'{29389,14493},
    '{29389,-14493},'{6393,-32138},'{-21605,-24636},'{-32698,2143},
    '{-18205,27246},'{10533,31029},'{31029,10533},'{27246,-18205},
    '{2143,-32698},'{-24636,-21605},'{-32138,6393},'{-14493,29389}
  };

  function automatic logic signed [SAMPLE_W-1:0] rom_sin(input logic [ROM_IDX_W-1:0] idx);
    rom_sin = SAMPLE_W'(ROM_SC[idx][0]);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rom_cos(input logic [ROM_IDX_W-1:0] idx);
    rom_cos = SAMPLE_W'(ROM_SC[idx][1]);
  endfunction

endpackage

// ===== rtl/qcr_ctrl.sv =====
module qcr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qcr_pkg::dp_stat_t stat,
  output qcr_pkg::dp_ctrl_t ctrl
);
  import qcr_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        case (stat.cmd)
          CMD_ACC:   state_nxt = S_ACC_ADD;
          CMD_RATIO: state_nxt = S_PROD;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_ACC_ADD:  state_nxt = S_DONE;
      S_PROD: begin
        if (stat.prod_done) state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: state_nxt = stat.den_zero ? S_DONE : S_DIV;
      S_DIV: begin
        if (stat.div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctrl     = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        ctrl.load = in_valid;
      end
      S_START: begin
        ctrl.acc_mul    = (stat.cmd == CMD_ACC);
        ctrl.clear      = (stat.cmd == CMD_CLEAR);
        ctrl.prod_start = (stat.cmd == CMD_RATIO);
      end
      S_ACC_ADD:  ctrl.acc_add = 1'b1;
      S_PROD:     ctrl.prod_step = 1'b1;
      S_DIV_INIT: ctrl.div_init = 1'b1;
      S_DIV:      ctrl.div_step = !stat.div_done;
      S_DONE:     ctrl.finish = !stat.out_busy;
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

// ===== rtl/qcr_dp.sv =====
module qcr_dp #(
  parameter int TABLE_DEPTH     = qcr_pkg::TABLE_DEPTH_DEF,
  parameter int RATIO_FRAC_BITS = qcr_pkg::RATIO_FRAC_BITS_DEF,
  parameter int ACC_WIDTH       = qcr_pkg::ACC_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  qcr_pkg::dp_ctrl_t                    ctrl,
  output qcr_pkg::dp_stat_t                    stat,
  input  logic                                 cfg_we,
  input  logic [qcr_pkg::TSEL_W-1:0]           cfg_data,
  input  logic [1:0]                           in_command,
  input  logic signed [qcr_pkg::SAMPLE_W-1:0]  in_ref_sample,
  input  logic signed [qcr_pkg::SAMPLE_W-1:0]  in_meas_sample,
  input  logic                                 in_last_in_block,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [qcr_pkg::RATIO_W-1:0]   out_ratio_real,
  output logic signed [qcr_pkg::RATIO_W-1:0]   out_ratio_imag,
  output logic [1:0]                           out_ratio_status,
  output logic signed [qcr_pkg::SUM_W-1:0]     out_meas_sin_sum,
  output logic signed [qcr_pkg::SUM_W-1:0]     out_meas_cos_sum,
  output logic signed [qcr_pkg::SUM_W-1:0]     out_ref_sin_sum,
  output logic signed [qcr_pkg::SUM_W-1:0]     out_ref_cos_sum
);
  import qcr_pkg::*;

  localparam int POS_W = $clog2(TABLE_DEPTH);
  localparam int ITER  = 128 + RATIO_FRAC_BITS;
  localparam int CNT_W = $clog2(ITER + 1);
  localparam int PW    = 2 * SAMPLE_W;
  localparam int QW    = 41;

  // latched item
  cmd_t                       cmd_r;
  logic signed [SAMPLE_W-1:0] ref_r, meas_r;
  logic                       last_r;
  logic [TSEL_W-1:0]          tsel_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= cmd_t'(in_command);
      ref_r  <= in_ref_sample;
      meas_r <= in_meas_sample;
      last_r <= in_last_in_block;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsel_r <= TSEL_W'(TSEL_RESET);
    end else if (cfg_we) begin
      tsel_r <= cfg_data;
    end
  end

  // table position and per-table phase
  logic [POS_W-1:0]   pos_r;
  logic [PHASE_W-1:0] phase_r [NUM_TABLES];
  logic               pos_wrap;

  assign pos_wrap = last_r || ((POS_W + 1)'(pos_r) + 1'b1 >= (POS_W + 1)'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int t = 0; t < NUM_TABLES; t++) phase_r[t] <= '0;
    end else if (ctrl.acc_add) begin
      if (pos_wrap) begin
        pos_r <= '0;
        for (int t = 0; t < NUM_TABLES; t++) phase_r[t] <= '0;
      end else begin
        pos_r <= pos_r + 1'b1;
        for (int t = 0; t < NUM_TABLES; t++) begin
          if (phase_r[t] + 1'b1 == PHASE_W'(ROM_PERIOD[t])) phase_r[t] <= '0;
          else phase_r[t] <= phase_r[t] + 1'b1;
        end
      end
    end
  end

  // rom lookup and sample products
  logic [TSEL_W-1:0]          sel;
  logic [ROM_IDX_W-1:0]       rom_idx;
  logic signed [SAMPLE_W-1:0] sn, cs;
  logic signed [PW-1:0]       p_ms_r, p_mc_r, p_rs_r, p_rc_r;

  always_comb begin
    sel = (tsel_r > TSEL_W'(TSEL_MAX)) ? TSEL_W'(TSEL_MAX) : tsel_r;
    rom_idx = '0;
    for (int t = 0; t < NUM_TABLES; t++) begin
      if (sel == TSEL_W'(t)) rom_idx = ROM_IDX_W'(ROM_BASE[t]) + ROM_IDX_W'(phase_r[t]);
    end
    sn = rom_sin(rom_idx);
    cs = rom_cos(rom_idx);
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_mul) begin
      p_ms_r <= meas_r * sn;
      p_mc_r <= meas_r * cs;
      p_rs_r <= ref_r * sn;
      p_rc_r <= ref_r * cs;
    end
  end

  // accumulators
  logic signed [ACC_WIDTH-1:0] ms_acc_r, mc_acc_r, rs_acc_r, rc_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      ms_acc_r <= '0;
      mc_acc_r <= '0;
      rs_acc_r <= '0;
      rc_acc_r <= '0;
    end else if (ctrl.acc_add) begin
      ms_acc_r <= ms_acc_r + ACC_WIDTH'(p_ms_r);
      mc_acc_r <= mc_acc_r + ACC_WIDTH'(p_mc_r);
      rs_acc_r <= rs_acc_r + ACC_WIDTH'(p_rs_r);
      rc_acc_r <= rc_acc_r + ACC_WIDTH'(p_rc_r);
    end
  end

  // sums seen as 64-bit values
  logic signed [SUM_W-1:0] ms64, mc64, rs64, rc64;
  assign ms64 = SUM_W'(ms_acc_r);
  assign mc64 = SUM_W'(mc_acc_r);
  assign rs64 = SUM_W'(rs_acc_r);
  assign rc64 = SUM_W'(rc_acc_r);

  // cross products, one 32x32 partial product a cycle
  logic [SUM_W-1:0]   m_ms_r, m_mc_r, m_rs_r, m_rc_r;
  logic               n_ms_r, n_mc_r, n_rs_r, n_rc_r;
  logic [STEP_W-1:0]  step_r;
  logic [2:0]         k;
  logic [1:0]         j;
  logic [SUM_W-1:0]   op_a, op_b;
  logic               op_neg;
  logic [31:0]        half_a, half_b;
  logic [63:0]        pp_r;
  logic [2:0]         pk_r;
  logic [1:0]         pshift_r;
  logic               pneg_r, pv_r;
  logic [127:0]       den_r;
  logic signed [129:0] nr_r, ni_r;
  logic [127:0]       term;
  logic signed [129:0] sterm;
  logic               issue;

  assign k     = step_r[4:2];
  assign j     = step_r[1:0];
  assign issue = ctrl.prod_step && (step_r < STEP_W'(PROD_STEPS));

  always_comb begin
    op_a = m_rc_r; op_b = m_rc_r; op_neg = 1'b0;
    case (k)
      3'd0: begin op_a = m_rc_r; op_b = m_rc_r; op_neg = 1'b0; end
      3'd1: begin op_a = m_rs_r; op_b = m_rs_r; op_neg = 1'b0; end
      3'd2: begin op_a = m_mc_r; op_b = m_rc_r; op_neg = n_mc_r ^ n_rc_r; end
      3'd3: begin op_a = m_ms_r; op_b = m_rs_r; op_neg = n_ms_r ^ n_rs_r; end
      3'd4: begin op_a = m_ms_r; op_b = m_rc_r; op_neg = n_ms_r ^ n_rc_r; end
      3'd5: begin op_a = m_mc_r; op_b = m_rs_r; op_neg = !(n_mc_r ^ n_rs_r); end
      default: begin op_a = m_rc_r; op_b = m_rc_r; op_neg = 1'b0; end
    endcase
    half_a = j[1] ? op_a[63:32] : op_a[31:0];
    half_b = j[0] ? op_b[63:32] : op_b[31:0];
  end

  always_comb begin
    case (pshift_r)
      2'd0:    term = {64'd0, pp_r};
      2'd1:    term = {32'd0, pp_r, 32'd0};
      default: term = {pp_r, 64'd0};
    endcase
    sterm = pneg_r ? -$signed({2'b00, term}) : $signed({2'b00, term});
  end

  always_ff @(posedge clk) begin
    if (ctrl.prod_start) begin
      m_ms_r <= ms64[SUM_W-1] ? -ms64 : ms64;
      m_mc_r <= mc64[SUM_W-1] ? -mc64 : mc64;
      m_rs_r <= rs64[SUM_W-1] ? -rs64 : rs64;
      m_rc_r <= rc64[SUM_W-1] ? -rc64 : rc64;
      n_ms_r <= ms64[SUM_W-1];
      n_mc_r <= mc64[SUM_W-1];
      n_rs_r <= rs64[SUM_W-1];
      n_rc_r <= rc64[SUM_W-1];
      step_r <= '0;
      pv_r   <= 1'b0;
      den_r  <= '0;
      nr_r   <= '0;
      ni_r   <= '0;
    end else if (ctrl.prod_step) begin
      pv_r <= issue;
      if (issue) begin
        step_r   <= step_r + 1'b1;
        pp_r     <= half_a * half_b;
        pk_r     <= k;
        pshift_r <= 2'(j[1]) + 2'(j[0]);
        pneg_r   <= op_neg;
      end
      if (pv_r) begin
        if (pk_r < 3'd2)      den_r <= den_r + term;
        else if (pk_r < 3'd4) nr_r  <= nr_r + sterm;
        else                  ni_r  <= ni_r + sterm;
      end
    end
  end

  // restoring division, both parts in parallel, one quotient bit a cycle
  logic [127:0]     num_re_r, num_im_r, rem_re_r, rem_im_r;
  logic             neg_re_r, neg_im_r, big_re_r, big_im_r;
  logic [QW-1:0]    q_re_r, q_im_r;
  logic [CNT_W-1:0] cnt_r;
  logic [128:0]     sh_re, sh_im;
  logic             ge_re, ge_im;
  logic signed [129:0] abs_re, abs_im;

  assign abs_re = nr_r[129] ? -nr_r : nr_r;
  assign abs_im = ni_r[129] ? -ni_r : ni_r;
  assign sh_re  = {rem_re_r, num_re_r[127]};
  assign sh_im  = {rem_im_r, num_im_r[127]};
  assign ge_re  = sh_re >= {1'b0, den_r};
  assign ge_im  = sh_im >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      num_re_r <= abs_re[127:0];
      num_im_r <= abs_im[127:0];
      neg_re_r <= nr_r[129];
      neg_im_r <= ni_r[129];
      rem_re_r <= '0;
      rem_im_r <= '0;
      q_re_r   <= '0;
      q_im_r   <= '0;
      big_re_r <= 1'b0;
      big_im_r <= 1'b0;
      cnt_r    <= '0;
    end else if (ctrl.div_step) begin
      num_re_r <= {num_re_r[126:0], 1'b0};
      num_im_r <= {num_im_r[126:0], 1'b0};
      rem_re_r <= ge_re ? 128'(sh_re - {1'b0, den_r}) : sh_re[127:0];
      rem_im_r <= ge_im ? 128'(sh_im - {1'b0, den_r}) : sh_im[127:0];
      big_re_r <= big_re_r | q_re_r[QW-1];
      big_im_r <= big_im_r | q_im_r[QW-1];
      q_re_r   <= {q_re_r[QW-2:0], ge_re};
      q_im_r   <= {q_im_r[QW-2:0], ge_im};
      cnt_r    <= cnt_r + 1'b1;
    end
  end

  // saturation to the 32-bit result
  logic [QW-1:0]        lim_re, lim_im, qs_re, qs_im;
  logic                 sat_re, sat_im;
  logic [RATIO_W-1:0]   r_re, r_im;

  always_comb begin
    lim_re = neg_re_r ? QW'(33'h1_0000_0000 >> 1) : QW'(32'h7FFF_FFFF);
    lim_im = neg_im_r ? QW'(33'h1_0000_0000 >> 1) : QW'(32'h7FFF_FFFF);
    sat_re = big_re_r || (q_re_r > lim_re);
    sat_im = big_im_r || (q_im_r > lim_im);
    qs_re  = sat_re ? lim_re : q_re_r;
    qs_im  = sat_im ? lim_im : q_im_r;
    r_re   = neg_re_r ? RATIO_W'(-qs_re) : RATIO_W'(qs_re);
    r_im   = neg_im_r ? RATIO_W'(-qs_im) : RATIO_W'(qs_im);
  end

  // output register
  logic out_valid_r;
  logic den_zero;
  assign den_zero = (den_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_meas_sin_sum <= ms64;
      out_meas_cos_sum <= mc64;
      out_ref_sin_sum  <= rs64;
      out_ref_cos_sum  <= rc64;
      if (cmd_r != CMD_RATIO) begin
        out_ratio_real   <= '0;
        out_ratio_imag   <= '0;
        out_ratio_status <= ST_NONE;
      end else if (den_zero) begin
        out_ratio_real   <= '0;
        out_ratio_imag   <= '0;
        out_ratio_status <= ST_REF_ZERO;
      end else begin
        out_ratio_real   <= r_re;
        out_ratio_imag   <= r_im;
        out_ratio_status <= (sat_re || sat_im) ? ST_SAT : ST_OK;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign stat.cmd       = cmd_r;
  assign stat.prod_done = (step_r == STEP_W'(PROD_STEPS)) && !pv_r;
  assign stat.den_zero  = den_zero;
  assign stat.div_done  = (cnt_r == CNT_W'(ITER));
  assign stat.out_busy  = out_valid_r && out_stall;

endmodule

// ===== rtl/quadrature_correlator_ratio.sv =====
// Quadrature correlator with complex ratio. Each accumulate item multiplies the
// reference and measured samples by the selected sine/cosine table entry and adds
// the four products into wrapping accumulators; the table position restarts after
// an item marked last or at the end of the table. A clear item zeroes the sums; a
// ratio item returns measured/reference in Q3.RATIO_FRAC_BITS, saturating, with
// cosine as the real axis. Every item returns one result carrying all four sums.
// One item is worked at a time: a ratio item forms the 24 partial products of the
// shared 32x32 multiplier and then runs the bit-serial divider, which is skipped
// when the reference sums are zero. A finished result waits in the output register
// while the next item is taken.
module quadrature_correlator_ratio #(
  parameter int TABLE_DEPTH     = qcr_pkg::TABLE_DEPTH_DEF,
  parameter int RATIO_FRAC_BITS = qcr_pkg::RATIO_FRAC_BITS_DEF,
  parameter int ACC_WIDTH       = qcr_pkg::ACC_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [qcr_pkg::TSEL_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_command,
  input  logic signed [qcr_pkg::SAMPLE_W-1:0]  in_ref_sample,
  input  logic signed [qcr_pkg::SAMPLE_W-1:0]  in_meas_sample,
  input  logic                                 in_last_in_block,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [qcr_pkg::RATIO_W-1:0]   out_ratio_real,
  output logic signed [qcr_pkg::RATIO_W-1:0]   out_ratio_imag,
  output logic [1:0]                           out_ratio_status,
  output logic signed [qcr_pkg::SUM_W-1:0]     out_meas_sin_sum,
  output logic signed [qcr_pkg::SUM_W-1:0]     out_meas_cos_sum,
  output logic signed [qcr_pkg::SUM_W-1:0]     out_ref_sin_sum,
  output logic signed [qcr_pkg::SUM_W-1:0]     out_ref_cos_sum
);
  import qcr_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // sequencer
  qcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // arithmetic and storage
  qcr_dp #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
    .ACC_WIDTH       (ACC_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_command       (in_command),
    .in_ref_sample    (in_ref_sample),
    .in_meas_sample   (in_meas_sample),
    .in_last_in_block (in_last_in_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ratio_real   (out_ratio_real),
    .out_ratio_imag   (out_ratio_imag),
    .out_ratio_status (out_ratio_status),
    .out_meas_sin_sum (out_meas_sin_sum),
    .out_meas_cos_sum (out_meas_cos_sum),
    .out_ref_sin_sum  (out_ref_sin_sum),
    .out_ref_cos_sum  (out_ref_cos_sum)
  );

endmodule

// ===== rtl/qcr_checker.sv =====
module qcr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_ratio_real,
  input logic [31:0] out_ratio_imag,
  input logic [1:0]  out_ratio_status
);
  import qcr_pkg::*;

  // a stalled item stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // a stalled ratio stays put
  a_hold_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_ratio_real) && $stable(out_ratio_imag))
    else $error("stalled ratio changed");

  // no ratio means zero parts
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ratio_status == ST_NONE |-> out_ratio_real == '0 && out_ratio_imag == '0)
    else $error("ratio parts set without a ratio");

  // zero reference gives zero parts
  a_refzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ratio_status == ST_REF_ZERO
      |-> out_ratio_real == '0 && out_ratio_imag == '0)
    else $error("zero reference produced nonzero ratio");

endmodule

bind quadrature_correlator_ratio qcr_checker u_qcr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_ratio_real   (out_ratio_real),
  .out_ratio_imag   (out_ratio_imag),
  .out_ratio_status (out_ratio_status)
);
